// File: sv/nggr_pkg.sv
// Shared types, constants and helper functions for the GGA sentence receiver.
// No dependencies; every other file but nggr_in_stage imports this package.
package nggr_pkg;

    // Longest body kept before the checksum digits are forced.
    localparam int BODY_LENGTH   = 80;
    localparam int BODY_CNT_W    = $clog2(BODY_LENGTH + 1);
    localparam int BODY_INDEX_W  = 7;
    localparam int TAG_POS_W     = 3;
    localparam int MAX_TAG_INDEX = 4;
    localparam int HEX_CNT_W     = 2;
    localparam int HEX_DIGITS    = 2;

    // Characters that steer the parser.
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_P      = 8'h50;

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_TAG,
        PH_BODY,
        PH_CSUM
    } phase_t;

    // One result transaction.
    typedef struct packed {
        logic                    body_valid;
        logic [7:0]              body_byte;
        logic [BODY_INDEX_W-1:0] body_index;
        logic                    body_restart;
        logic                    sentence_done;
        logic                    checksum_ok;
    } result_t;

    // Expected character at each position of the GPGGA tag.
    function automatic logic [7:0] tag_char(input logic [TAG_POS_W-1:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = CH_G;
            3'd1:    ch = CH_P;
            3'd2:    ch = CH_G;
            3'd3:    ch = CH_G;
            3'd4:    ch = CH_A;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Hex digit value; only uppercase letters decode correctly, others wrap.
    function automatic logic [7:0] hex_value(input logic [7:0] ch);
        logic [7:0] v;
        if (ch >= CH_A) begin
            v = ch + 8'd10 - CH_A;
        end else begin
            v = ch - CH_ZERO;
        end
        return v;
    endfunction

endpackage

// File: sv/nggr_in_stage.sv
// Input register for received bytes, with valid/ready handshake.
// Uses nothing from nggr_pkg; holds one byte transaction.
module nggr_in_stage (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_byte,
    input  logic       advance,
    output logic       valid,
    output logic [7:0] rx_byte
);
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;

    // The stage can take a new byte when empty or when its byte moves on.
    assign s_ready       = !in_valid_reg || advance;
    assign in_valid_next = s_valid ? 1'b1 : (in_valid_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_byte;
        end
    end

    assign valid   = in_valid_reg;
    assign rx_byte = in_byte_reg;
endmodule

// File: sv/nggr_parser.sv
// Sentence state machine: tag match, body indexing, XOR checksum and hex decode.
// Depends on nggr_pkg for the phase type, result struct and character helpers.
module nggr_parser (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  logic [7:0]       rx_byte,
    output nggr_pkg::result_t result
);
    import nggr_pkg::*;

    phase_t                  phase_reg, phase_next;
    logic [TAG_POS_W-1:0]    tag_pos_reg, tag_pos_next;
    logic [BODY_CNT_W-1:0]   body_len_reg, body_len_next;
    logic [7:0]              run_xor_reg, run_xor_next;
    logic [7:0]              body_xor_reg, body_xor_next;
    logic [7:0]              sent_sum_reg, sent_sum_next;
    logic [HEX_CNT_W-1:0]    hex_cnt_reg, hex_cnt_next;

    logic [BODY_CNT_W-1:0]   len_inc;
    logic                    body_end;
    logic                    tag_hit;

    assign len_inc  = body_len_reg + BODY_CNT_W'(1);
    assign body_end = (rx_byte == CH_STAR) || (len_inc >= BODY_CNT_W'(BODY_LENGTH));
    assign tag_hit  = (rx_byte == tag_char(tag_pos_reg));

    // Result for the byte being processed.
    always_comb begin
        result = '0;
        case (phase_reg)
            PH_BODY: begin
                result.body_valid   = 1'b1;
                result.body_byte    = rx_byte;
                result.body_index   = BODY_INDEX_W'(body_len_reg);
                result.body_restart = !body_end && (rx_byte == CH_DOLLAR);
            end
            PH_CSUM: begin
                if (hex_cnt_reg == HEX_CNT_W'(HEX_DIGITS)) begin
                    result.sentence_done = 1'b1;
                    result.checksum_ok   = (body_xor_reg == sent_sum_reg);
                end
            end
            default: begin
                result = '0;
            end
        endcase
    end

    // Next-state logic.
    always_comb begin
        phase_next    = phase_reg;
        tag_pos_next  = tag_pos_reg;
        body_len_next = body_len_reg;
        run_xor_next  = run_xor_reg;
        body_xor_next = body_xor_reg;
        sent_sum_next = sent_sum_reg;
        hex_cnt_next  = hex_cnt_reg;
        case (phase_reg)
            PH_WAIT: begin
                if (rx_byte == CH_DOLLAR) begin
                    body_len_next = '0;
                    tag_pos_next  = '0;
                    run_xor_next  = '0;
                    phase_next    = PH_TAG;
                end
            end
            PH_TAG: begin
                run_xor_next = run_xor_reg ^ rx_byte;
                if (tag_hit) begin
                    if (tag_pos_reg == TAG_POS_W'(MAX_TAG_INDEX)) begin
                        phase_next = PH_BODY;
                    end else begin
                        tag_pos_next = tag_pos_reg + TAG_POS_W'(1);
                    end
                end else begin
                    phase_next = PH_WAIT;
                end
            end
            PH_BODY: begin
                run_xor_next  = run_xor_reg ^ rx_byte;
                body_len_next = len_inc;
                if (body_end) begin
                    // The terminating byte stays out of the checksum.
                    body_xor_next = run_xor_reg;
                    sent_sum_next = '0;
                    hex_cnt_next  = '0;
                    phase_next    = PH_CSUM;
                end else if (rx_byte == CH_DOLLAR) begin
                    body_len_next = '0;
                    tag_pos_next  = '0;
                    run_xor_next  = '0;
                    phase_next    = PH_TAG;
                end else begin
                    body_xor_next = run_xor_reg ^ rx_byte;
                end
            end
            PH_CSUM: begin
                if (hex_cnt_reg != HEX_CNT_W'(HEX_DIGITS)) begin
                    sent_sum_next = {sent_sum_reg[3:0], 4'h0} + hex_value(rx_byte);
                    hex_cnt_next  = hex_cnt_reg + HEX_CNT_W'(1);
                end else begin
                    phase_next = PH_WAIT;
                end
            end
            default: begin
                phase_next = PH_WAIT;
            end
        endcase
    end

    // State advances only when a byte moves into the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_WAIT;
            tag_pos_reg  <= '0;
            body_len_reg <= '0;
            run_xor_reg  <= '0;
            body_xor_reg <= '0;
            sent_sum_reg <= '0;
            hex_cnt_reg  <= '0;
        end else if (step) begin
            phase_reg    <= phase_next;
            tag_pos_reg  <= tag_pos_next;
            body_len_reg <= body_len_next;
            run_xor_reg  <= run_xor_next;
            body_xor_reg <= body_xor_next;
            sent_sum_reg <= sent_sum_next;
            hex_cnt_reg  <= hex_cnt_next;
        end
    end
endmodule

// File: sv/nggr_out_stage.sv
// Result register with valid/ready handshake toward the consumer.
// Depends on nggr_pkg for the result struct.
module nggr_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  nggr_pkg::result_t result_in,
    output logic              can_load,
    output logic              m_valid,
    input  logic              m_ready,
    output nggr_pkg::result_t result_out
);
    import nggr_pkg::*;

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t result_reg;

    // A new result may enter when the register is empty or being drained.
    assign can_load       = !out_valid_reg || m_ready;
    assign out_valid_next = load ? 1'b1 : (out_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result_in;
        end
    end

    assign m_valid    = out_valid_reg;
    assign result_out = result_reg;
endmodule

// File: sv/nmea_gga_sentence_receiver.sv
// Top level of the GGA sentence receiver: input register, parser, result register.
// Depends on nggr_pkg, nggr_in_stage, nggr_parser and nggr_out_stage.
//
// Usage:
//   The input channel (s_valid, s_ready, s_rx_byte) takes one received serial
//   character per transaction. Every character yields exactly one result
//   transaction on the output channel (m_valid, m_ready, m_* fields).
//   Body characters of a GPGGA sentence come out with body_valid and their
//   index; a dollar inside the body flags body_restart; the character after
//   the two checksum digits flags sentence_done with checksum_ok.
//   A character's result passes from the input register through the parser
//   step into the result register, which raises m_valid.
//   Throughput is one character per cycle while m_ready stays high, set by
//   the single parser step between the input register and the result register.
//   Synchronous active-low reset empties both registers and returns the parser
//   to waiting for a dollar.
//   When the consumer holds m_ready low, the result register holds its
//   transaction, the input register fills, and s_ready then drops until
//   results drain.
module nmea_gga_sentence_receiver (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [7:0]                       s_rx_byte,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_body_valid,
    output logic [7:0]                       m_body_byte,
    output logic [nggr_pkg::BODY_INDEX_W-1:0] m_body_index,
    output logic                             m_body_restart,
    output logic                             m_sentence_done,
    output logic                             m_checksum_ok
);
    import nggr_pkg::*;

    logic       in_valid;
    logic [7:0] in_byte;
    logic       out_can_load;
    logic       advance;
    result_t    step_result;
    result_t    out_result;

    // A byte moves on when it is present and the result register has room.
    assign advance = in_valid && out_can_load;

    nggr_in_stage u_in (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_byte  (s_rx_byte),
        .advance (advance),
        .valid   (in_valid),
        .rx_byte (in_byte)
    );

    nggr_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .rx_byte (in_byte),
        .result  (step_result)
    );

    nggr_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (advance),
        .result_in  (step_result),
        .can_load   (out_can_load),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .result_out (out_result)
    );

    assign m_body_valid    = out_result.body_valid;
    assign m_body_byte     = out_result.body_byte;
    assign m_body_index    = out_result.body_index;
    assign m_body_restart  = out_result.body_restart;
    assign m_sentence_done = out_result.sentence_done;
    assign m_checksum_ok   = out_result.checksum_ok;
endmodule

// File: sv/nggr_checker.sv
// Port-level checks for the GGA sentence receiver, bound to the top level.
// Depends on nggr_pkg for the character and length constants.
module nggr_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic                             m_body_valid,
    input logic [7:0]                       m_body_byte,
    input logic [nggr_pkg::BODY_INDEX_W-1:0] m_body_index,
    input logic                             m_body_restart,
    input logic                             m_sentence_done,
    input logic                             m_checksum_ok
);
    import nggr_pkg::*;

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // Non-body results carry zero payload; body indexes stay within the limit.
    a_body_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_body_valid ? (32'(m_body_index) < BODY_LENGTH)
                                  : (m_body_byte == 8'h00 && m_body_index == '0)))
        else $error("body fields inconsistent with body_valid");

    // A restart is reported only on a dollar that was passed as body.
    a_restart_dollar: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_body_restart) |-> (m_body_valid && m_body_byte == CH_DOLLAR))
        else $error("restart without a body dollar");

    // Checksum status only accompanies completion, and completion is never body.
    a_done_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((!m_checksum_ok || m_sentence_done)
                     && !(m_sentence_done && m_body_valid)))
        else $error("completion flags inconsistent");

    // A stalled result stays valid and keeps its body byte and completion flag.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_body_byte)
                                   && $stable(m_sentence_done)))
        else $error("stalled result changed");
endmodule

bind nmea_gga_sentence_receiver nggr_checker u_nggr_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_body_valid    (m_body_valid),
    .m_body_byte     (m_body_byte),
    .m_body_index    (m_body_index),
    .m_body_restart  (m_body_restart),
    .m_sentence_done (m_sentence_done),
    .m_checksum_ok   (m_checksum_ok)
);

// File: bench/gga_result_checker.sv
// Result checker for the GGA sentence receiver: watches both channels,
// predicts every result transaction and compares it field by field.
// Depends on nggr_pkg for the character codes, widths and the result type.
module gga_result_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic [7:0]                        s_rx_byte,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic                              m_body_valid,
    input  logic [7:0]                        m_body_byte,
    input  logic [nggr_pkg::BODY_INDEX_W-1:0] m_body_index,
    input  logic                              m_body_restart,
    input  logic                              m_sentence_done,
    input  logic                              m_checksum_ok,
    output int                                error_count,
    output int                                pending_count
);
    import nggr_pkg::*;

    // The five tag characters, first one in the top byte.
    localparam logic [39:0] GGA_TAG = {CH_G, CH_P, CH_G, CH_G, CH_A};

    // Parser state as the receiver should hold it.
    phase_t                 parse_phase;
    logic [TAG_POS_W-1:0]   tag_pos;
    int unsigned            stored_count;
    logic [7:0]             running_sum;
    logic [7:0]             latched_sum;
    logic [7:0]             received_sum;
    int unsigned            digits_taken;

    result_t                predicted_q[$];
    result_t                got;
    result_t                want;

    // A dollar opens a new sentence: clear the count and the checksum.
    function automatic void open_sentence();
        stored_count = 0;
        tag_pos      = '0;
        running_sum  = 8'h00;
        parse_phase  = PH_TAG;
    endfunction

    // Advance the parser by one character and return the result it causes.
    function automatic result_t parse_char(input logic [7:0] ch);
        result_t    r;
        logic [7:0] prior_sum;
        logic [7:0] digit;
        r = '0;
        case (parse_phase)
            PH_WAIT: begin
                if (ch == CH_DOLLAR) begin
                    open_sentence();
                end
            end
            PH_TAG: begin
                running_sum = running_sum ^ ch;
                if (tag_pos <= MAX_TAG_INDEX && ch == GGA_TAG[39 - 8 * tag_pos -: 8]) begin
                    if (tag_pos == MAX_TAG_INDEX) begin
                        parse_phase = PH_BODY;
                    end else begin
                        tag_pos = tag_pos + 1'b1;
                    end
                end else begin
                    parse_phase = PH_WAIT;
                end
            end
            PH_BODY: begin
                prior_sum    = running_sum;
                running_sum  = running_sum ^ ch;
                r.body_valid = 1'b1;
                r.body_byte  = ch;
                r.body_index = stored_count[BODY_INDEX_W-1:0];
                stored_count = stored_count + 1;
                // The terminator or the length limit closes the body; the
                // byte that closes it stays out of the checksum.
                if (ch == CH_STAR || stored_count >= BODY_LENGTH) begin
                    latched_sum  = prior_sum;
                    received_sum = 8'h00;
                    digits_taken = 0;
                    parse_phase  = PH_CSUM;
                end else if (ch == CH_DOLLAR) begin
                    r.body_restart = 1'b1;
                    open_sentence();
                end else begin
                    latched_sum = running_sum;
                end
            end
            default: begin
                if (digits_taken < HEX_DIGITS) begin
                    // Only uppercase letters decode; anything else wraps.
                    if (ch >= CH_A) begin
                        digit = ch + 8'd10 - CH_A;
                    end else begin
                        digit = ch - CH_ZERO;
                    end
                    received_sum = {received_sum[3:0], 4'h0} + digit;
                    digits_taken = digits_taken + 1;
                end else begin
                    r.sentence_done = 1'b1;
                    r.checksum_ok   = (latched_sum == received_sum);
                    parse_phase     = PH_WAIT;
                end
            end
        endcase
        return r;
    endfunction

    // Report one field that differs from its prediction.
    task automatic compare_field(input string fname, input logic [7:0] want_v,
                                 input logic [7:0] seen_v);
        if (seen_v !== want_v) begin
            $display("%0t result_check: %s expected 0x%0h, actual 0x%0h",
                     $time, fname, want_v, seen_v);
            error_count = error_count + 1;
        end
    endtask

    initial begin
        error_count   = 0;
        pending_count = 0;
    end

    // Predict each accepted input transaction and check each result transaction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            parse_phase  = PH_WAIT;
            tag_pos      = '0;
            stored_count = 0;
            running_sum  = 8'h00;
            latched_sum  = 8'h00;
            received_sum = 8'h00;
            digits_taken = 0;
            predicted_q.delete();
        end else begin
            if (s_valid && s_ready) begin
                predicted_q.push_back(parse_char(s_rx_byte));
            end
            if (m_valid && m_ready) begin
                got = {m_body_valid, m_body_byte, m_body_index, m_body_restart,
                       m_sentence_done, m_checksum_ok};
                if (predicted_q.size() == 0) begin
                    $display("%0t result_check: unexpected result transaction 0x%0h",
                             $time, got);
                    error_count = error_count + 1;
                end else begin
                    want = predicted_q.pop_front();
                    compare_field("body_valid", want.body_valid, got.body_valid);
                    compare_field("body_byte", want.body_byte, got.body_byte);
                    compare_field("body_index", want.body_index, got.body_index);
                    compare_field("body_restart", want.body_restart, got.body_restart);
                    compare_field("sentence_done", want.sentence_done, got.sentence_done);
                    compare_field("checksum_ok", want.checksum_ok, got.checksum_ok);
                end
            end
        end
        pending_count = predicted_q.size();
    end

endmodule

// File: bench/tb_top.sv
// Testbench top for the GGA sentence receiver: clock, reset, byte stimulus
// in several idling phases and the final verdict.
// Depends on nggr_pkg, nmea_gga_sentence_receiver and gga_result_checker.
module tb_top;
    import nggr_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 1750;
    localparam int DRAIN_CYCLES = 10;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [7:0]              s_rx_byte = 8'h00;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic                    m_body_valid;
    logic [7:0]              m_body_byte;
    logic [BODY_INDEX_W-1:0] m_body_index;
    logic                    m_body_restart;
    logic                    m_sentence_done;
    logic                    m_checksum_ok;

    int                      error_count;
    int                      pending_count;
    int unsigned             src_idle_pct = 0;
    int unsigned             sink_stall_pct = 0;
    int unsigned             bytes_sent = 0;
    int unsigned             cycle_count = 0;

    nmea_gga_sentence_receiver dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_body_valid    (m_body_valid),
        .m_body_byte     (m_body_byte),
        .m_body_index    (m_body_index),
        .m_body_restart  (m_body_restart),
        .m_sentence_done (m_sentence_done),
        .m_checksum_ok   (m_checksum_ok)
    );

    gga_result_checker result_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_body_valid    (m_body_valid),
        .m_body_byte     (m_body_byte),
        .m_body_index    (m_body_index),
        .m_body_restart  (m_body_restart),
        .m_sentence_done (m_sentence_done),
        .m_checksum_ok   (m_checksum_ok),
        .error_count     (error_count),
        .pending_count   (pending_count)
    );

    // Free-running clock, period 10.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Cycle counter with a hard stop in case the receiver hangs.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Result side back-pressure, redrawn every cycle.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Offer one byte, with optional idle cycles first, and wait for the
    // transaction to be accepted. Starts and ends at a falling edge.
    task automatic send_byte(input logic [7:0] b);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        bytes_sent = bytes_sent + 1;
        @(negedge aclk);
    endtask

    // ASCII hex digit for a nibble, optionally with a lowercase letter.
    function automatic logic [7:0] hex_char(input logic [3:0] v, input logic lower);
        if (v < 4'd10) begin
            return CH_ZERO + v;
        end
        return (CH_A + v - 8'd10) | (lower ? 8'h20 : 8'h00);
    endfunction

    // Send a dollar followed by the five tag bytes GPGGA, returning their XOR.
    task automatic send_tag(output logic [7:0] sum);
        logic [39:0] tag;
        tag = {CH_G, CH_P, CH_G, CH_G, CH_A};
        sum = 8'h00;
        send_byte(CH_DOLLAR);
        for (int i = 0; i < 5; i++) begin
            send_byte(tag[39 - 8 * i -: 8]);
            sum = sum ^ tag[39 - 8 * i -: 8];
        end
    endtask

    // One sentence with random content; mostly well formed, sometimes with a
    // broken tag, a restart, the length limit or a bad checksum.
    task automatic send_sentence();
        logic [39:0] tag;
        logic [7:0]  sum;
        logic [7:0]  ch;
        logic [7:0]  sent_sum;
        int unsigned body_len;
        int unsigned restart_at;
        int unsigned bad_pos;
        int unsigned style;
        bit          long_body;
        tag = {CH_G, CH_P, CH_G, CH_G, CH_A};

        // Broken tag: a random byte replaces one tag character.
        if ($urandom_range(99) < 8) begin
            bad_pos = $urandom_range(4);
            send_byte(CH_DOLLAR);
            for (int i = 0; i < bad_pos; i++) begin
                send_byte(tag[39 - 8 * i -: 8]);
            end
            send_byte(8'($urandom_range(255)));
            return;
        end

        send_tag(sum);
        long_body = ($urandom_range(99) < 4);
        body_len = long_body ? $urandom_range(BODY_LENGTH - 1, BODY_LENGTH + 2)
                             : $urandom_range(0, 24);
        restart_at = (!long_body && $urandom_range(99) < 6) ?
                     $urandom_range(0, body_len) : BODY_LENGTH + 10;

        // Body characters; the one that reaches the limit stays out of the sum.
        for (int i = 0; i < body_len && i < BODY_LENGTH; i++) begin
            if (i == restart_at) begin
                send_tag(sum);
            end
            do begin
                ch = ($urandom_range(99) < 20) ? 8'($urandom_range(255))
                                               : 8'($urandom_range(8'h20, 8'h7E));
            end while (ch == CH_DOLLAR || ch == CH_STAR);
            if (i == BODY_LENGTH - 1 && $urandom_range(1) == 1) begin
                ch = CH_DOLLAR;
            end
            send_byte(ch);
            if (i < BODY_LENGTH - 1) begin
                sum = sum ^ ch;
            end
        end
        if (body_len < BODY_LENGTH) begin
            send_byte(CH_STAR);
        end

        // Checksum digits: correct, wrong value, lowercase or garbage.
        style = $urandom_range(99);
        sent_sum = (style >= 70 && style < 80) ? sum ^ (8'h01 << $urandom_range(7)) : sum;
        if (style < 90) begin
            send_byte(hex_char(sent_sum[7:4], style >= 80));
            send_byte(hex_char(sent_sum[3:0], style >= 80));
        end else begin
            send_byte(8'($urandom_range(255)));
            send_byte(8'($urandom_range(255)));
        end

        // Completion byte, then perhaps a line feed.
        style = $urandom_range(9);
        if (style < 6) begin
            send_byte(8'h0D);
        end else if (style < 8) begin
            send_byte(CH_DOLLAR);
        end else begin
            send_byte(8'($urandom_range(255)));
        end
        if ($urandom_range(1) == 1) begin
            send_byte(8'h0A);
        end
    endtask

    // Hold the sender until every predicted result transaction has arrived.
    task automatic wait_drained();
        while (pending_count != 0) begin
            @(negedge aclk);
        end
    endtask

    // Reset, directed bytes, then random sentences over four idling phases.
    initial begin
        logic [7:0]  opening[$];
        int unsigned target;
        opening = '{8'h00, 8'hFF, CH_DOLLAR, CH_G, CH_P, CH_G, CH_G, CH_A, 8'h2C,
                    CH_DOLLAR, CH_G, CH_P, CH_G, CH_G, CH_A, 8'hFF, 8'h00, CH_STAR,
                    8'h61, 8'h39, CH_DOLLAR, CH_DOLLAR, CH_G, 8'h58};

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Waiting-state extremes, a restart, a terminator, a lowercase digit,
        // a dollar as completion byte and a tag mismatch.
        foreach (opening[i]) begin
            send_byte(opening[i]);
        end

        for (int p = 0; p < 4; p++) begin
            s_valid <= 1'b0;
            wait_drained();
            case (p)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 70; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 70; end
                default: begin src_idle_pct = 26; sink_stall_pct = 26; end
            endcase
            target = bytes_sent + RANDOM_ITEMS / 4;
            while (bytes_sent < target) begin
                if ($urandom_range(99) < 12) begin
                    repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
                end else begin
                    send_sentence();
                end
            end
        end

        s_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
